// ----- hdl/tpzr_pkg.sv -----
// Shared types, constants and small lookup functions for the torus point renderer.
// Depends on nothing; every other file of the block imports it.
package tpzr_pkg;

	// Default frame geometry.
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 24;

	// Fixed field widths.
	localparam int IDX_W   = 11;
	localparam int ANG_W   = 16;
	localparam int DEP_W   = 16;
	localparam int CHAR_W  = 8;
	localparam int SHADE_W = 4;
	localparam int FRAME_DW = DEP_W + SHADE_W;

	// Rotator datapath: 18-bit signed state, 16 iterations.
	localparam int TRIG_W       = 18;
	localparam int CORDIC_ITERS = 16;
	localparam int ITER_W       = 4;
	localparam logic signed [TRIG_W-1:0] CORDIC_X0    = 18'sd9949;
	localparam logic [ANG_W-1:0]         QUARTER_TURN = 16'd16384;
	localparam logic [ANG_W-1:0]         THREE_QUARTER = 16'd49152;
	localparam logic signed [TRIG_W-1:0] HALF_TURN    = 18'sd32768;
	localparam logic signed [TRIG_W-1:0] FULL_TURN    = 18'sd65536;

	// Multiplier datapath: Q2.14 operands carried in 24 signed bits.
	localparam int MW = 24;
	localparam int PW = 2 * MW;
	localparam logic signed [PW-1:0] ROUND_HALF  = 48'sd8192;
	localparam logic signed [MW-1:0] RING_RADIUS = 24'sd32768;
	localparam logic signed [MW-1:0] Z_OFFSET    = 24'sd81920;

	// Reciprocal divider.
	localparam int NUM_W = 31;
	localparam int DEN_W = MW;
	localparam logic [NUM_W-1:0] DIV_NUM_BASE = 31'h4000_0000;

	localparam logic [DEP_W-1:0]   DEPTH_SAT   = 16'hFFFF;
	localparam logic [SHADE_W-1:0] SHADE_BLANK = 4'd12;
	localparam logic [SHADE_W-1:0] SHADE_MAX   = 4'd11;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_PLOT,
		CMD_READ,
		CMD_NOP
	} cmd_t;

	typedef enum logic {
		REG_TILT,
		REG_SPIN
	} reg_idx_t;

	typedef enum logic [1:0] {
		TS_TUBE,
		TS_RING,
		TS_TILT,
		TS_SPIN
	} trig_sel_t;

	// Microprogram of the shared multiplier, one entry per rounded product.
	typedef enum logic [3:0] {
		MS_SASB,
		MS_CYCA,
		MS_CBCP,
		MS_T1SP_M,
		MS_CXM_X,
		MS_T2SB_X,
		MS_SACB,
		MS_SBCP,
		MS_T1SP_MN,
		MS_CXM_Y,
		MS_T2CB_Y,
		MS_CACX,
		MS_T1SP_Z,
		MS_CYSA_Z
	} mac_step_t;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_CORDIC,
		S_MUL,
		S_ACC,
		S_ZADD,
		S_DIV,
		S_PX,
		S_PXS,
		S_PY,
		S_PYS,
		S_CELL,
		S_ADDR,
		S_CMP,
		S_RESP
	} state_t;

	typedef struct packed {
		logic             start;
		logic [ANG_W-1:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} cordic_rsp_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	// Arctangent of 2^-i in units of 1/65536 turn.
	function automatic logic signed [TRIG_W-1:0] atan_step(input logic [ITER_W-1:0] i);
		logic signed [TRIG_W-1:0] v;
		case (i)
			4'd0:    v = 18'sd8192;
			4'd1:    v = 18'sd4836;
			4'd2:    v = 18'sd2555;
			4'd3:    v = 18'sd1297;
			4'd4:    v = 18'sd651;
			4'd5:    v = 18'sd326;
			4'd6:    v = 18'sd163;
			4'd7:    v = 18'sd81;
			4'd8:    v = 18'sd41;
			4'd9:    v = 18'sd20;
			4'd10:   v = 18'sd10;
			4'd11:   v = 18'sd5;
			4'd12:   v = 18'sd3;
			4'd13:   v = 18'sd1;
			4'd14:   v = 18'sd1;
			default: v = 18'sd0;
		endcase
		return v;
	endfunction

	// Brightness ramp; the blank code and anything above it read as a space.
	function automatic logic [CHAR_W-1:0] ramp_char(input logic [SHADE_W-1:0] code);
		logic [CHAR_W-1:0] c;
		case (code)
			4'd0:    c = ".";
			4'd1:    c = ",";
			4'd2:    c = "-";
			4'd3:    c = "~";
			4'd4:    c = ":";
			4'd5:    c = ";";
			4'd6:    c = "=";
			4'd7:    c = "!";
			4'd8:    c = "*";
			4'd9:    c = "#";
			4'd10:   c = "$";
			4'd11:   c = "@";
			default: c = " ";
		endcase
		return c;
	endfunction

endpackage

// ----- hdl/tpzr_cfg_if.sv -----
// Configuration write channel of the torus point renderer.
// Depends on tpzr_pkg.
interface tpzr_cfg_if import tpzr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             index;
	logic [ANG_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/tpzr_in_if.sv -----
// Command channel of the torus point renderer.
// Depends on tpzr_pkg.
interface tpzr_in_if import tpzr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       command;
	logic [ANG_W-1:0] tube_angle;
	logic [ANG_W-1:0] ring_angle;
	logic [IDX_W-1:0] cell_select;

	modport source (output valid, output command, output tube_angle, output ring_angle,
		output cell_select, input ready);
	modport sink (input valid, input command, input tube_angle, input ring_angle,
		input cell_select, output ready);
endinterface

// ----- hdl/tpzr_out_if.sv -----
// Result channel of the torus point renderer.
// Depends on tpzr_pkg.
interface tpzr_out_if import tpzr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  cell_index;
	logic [CHAR_W-1:0] cell_char;
	logic              updated;
	logic [DEP_W-1:0]  depth_value;

	modport source (output valid, output cell_index, output cell_char, output updated,
		output depth_value, input ready);
	modport sink (input valid, input cell_index, input cell_char, input updated,
		input depth_value, output ready);
endinterface

// ----- hdl/tpzr_cordic.sv -----
// Iterative rotation-mode CORDIC giving cosine and sine in Q2.14, one iteration a cycle.
// Depends on tpzr_pkg.
module tpzr_cordic import tpzr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cordic_req_t req,
	output cordic_rsp_t rsp
);

	logic                     busy_q;
	logic                     done_q;
	logic                     flip_q;
	logic [ITER_W-1:0]        it_q;
	logic signed [TRIG_W-1:0] x_q, y_q, z_q;
	logic signed [TRIG_W-1:0] cos_q, sin_q;

	logic signed [TRIG_W-1:0] z_ext, z_init;
	logic                     flip_init;
	logic signed [TRIG_W-1:0] dx, dy, x_nxt, y_nxt, z_nxt;
	logic                     last_it;

	// Fold the angle into plus or minus a quarter turn; the far half negates the result.
	always_comb begin
		z_ext     = signed'(TRIG_W'(req.angle));
		z_init    = z_ext;
		flip_init = 1'b0;
		if (req.angle >= QUARTER_TURN && req.angle < THREE_QUARTER) begin
			z_init    = z_ext - HALF_TURN;
			flip_init = 1'b1;
		end else if (req.angle >= THREE_QUARTER) begin
			z_init = z_ext - FULL_TURN;
		end
	end

	always_comb begin
		dx = y_q >>> it_q;
		dy = x_q >>> it_q;
		if (!z_q[TRIG_W-1]) begin
			x_nxt = x_q - dx;
			y_nxt = y_q + dy;
			z_nxt = z_q - atan_step(it_q);
		end else begin
			x_nxt = x_q + dx;
			y_nxt = y_q - dy;
			z_nxt = z_q + atan_step(it_q);
		end
	end

	assign last_it = (it_q == ITER_W'(CORDIC_ITERS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				it_q <= it_q + 1'b1;
				if (last_it) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= CORDIC_X0;
			y_q    <= '0;
			z_q    <= z_init;
			flip_q <= flip_init;
		end else if (busy_q) begin
			x_q <= x_nxt;
			y_q <= y_nxt;
			z_q <= z_nxt;
			if (last_it) begin
				cos_q <= flip_q ? -x_nxt : x_nxt;
				sin_q <= flip_q ? -y_nxt : y_nxt;
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.cos_v = cos_q;
	assign rsp.sin_v = sin_q;

endmodule

// ----- hdl/tpzr_divider.sv -----
// Restoring divider for the reciprocal depth, one quotient bit a cycle.
// Depends on tpzr_pkg.
module tpzr_divider import tpzr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0] r_shift, r_diff;
	logic           ge;

	// The dividend shifts out of the top of the quotient register as quotient bits shift in.
	always_comb begin
		r_shift = {rem_q, quo_q[NUM_W-1]};
		r_diff  = r_shift - {1'b0, den_q};
		ge      = (r_shift >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= ge ? r_diff[DEN_W-1:0] : r_shift[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ----- hdl/tpzr_frame_mem.sv -----
// Frame store: depth and shade code per cell, one write and one registered read port.
// Depends on tpzr_pkg for default sizes.
module tpzr_frame_mem import tpzr_pkg::*; #(
	parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = FRAME_DW
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/torus_point_zbuffer_render.sv -----
// Top level of the torus point renderer: sequencer, shared multiplier and frame store.
// Depends on tpzr_pkg, the three channel interfaces, tpzr_cordic, tpzr_divider
// and tpzr_frame_mem.
//
// Usage. Commands arrive on req, results leave on rsp, both valid/ready channels; a
// transaction happens on a clock edge with valid and ready high. Every command gives
// exactly one result. The cfg channel writes the tilt and spin angles and is always
// ready; write it only while no command is in flight.
// A plot takes four CORDIC runs on one shared rotator, fourteen rounded products on one
// shared multiplier and the bit-serial reciprocal divider, which is skipped when the
// depth divisor is not positive, then projection, a frame read and the depth test. A
// read of a cell in range reads the frame before its result; an out-of-range read and
// a no-operation go straight to the result. A clear walks the frame store one cell a
// cycle. One command is in work at a time, and the next is taken only after the last
// result has left the sequencer. After reset the block runs the same clearing walk and
// does not accept commands until it is done; configuration writes are taken throughout.
// The result sits in an output register. The block takes the next command while a
// result still waits there; when the receiver stalls, a finished result holds in the
// sequencer until the output register frees up.
module torus_point_zbuffer_render import tpzr_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic clk,
	input  logic arst_n,
	tpzr_cfg_if.sink  cfg,
	tpzr_in_if.sink   req,
	tpzr_out_if.source rsp
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int SW    = PW + 6;

	state_t    state_q, state_d;
	trig_sel_t ang_q;
	mac_step_t step_q;
	logic [AW-1:0] clr_addr_q;
	logic          sweep_rsp_q;
	logic          out_valid_q;

	// Configuration registers.
	logic [ANG_W-1:0] tilt_q, spin_q;

	// Per-command operands and intermediate values.
	logic [ANG_W-1:0]     tube_q, ring_q;
	logic                 is_read_q;
	logic signed [MW-1:0] cx_q, cy_q, cp_q, sp_q, ca_q, sa_q, cb_q, sb_q;
	logic signed [MW-1:0] t1_q, t2_q, m_q, x3_q, y3_q, z3_q;
	logic signed [PW-1:0] prod_q;
	logic [DEP_W-1:0]     d_q;
	logic [CW-1:0]        col_q;
	logic [RW-1:0]        row_q;
	logic [AW-1:0]        cell_q;

	// Finished result and the output register.
	logic [IDX_W-1:0]  res_index_q, out_index_q;
	logic [CHAR_W-1:0] res_char_q, out_char_q;
	logic              res_upd_q, out_upd_q;
	logic [DEP_W-1:0]  res_dep_q, out_dep_q;

	cordic_req_t cord_req;
	cordic_rsp_t cord_rsp;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_waddr;
	logic [FRAME_DW-1:0]  mem_wdata, mem_rdata;

	cmd_t                 cmd_in;
	logic                 sel_in_range;
	logic signed [MW-1:0] mul_a, mul_b, d_ext;
	logic signed [PW-1:0] rnd_full;
	logic signed [MW-1:0] rnd;
	logic signed [MW-1:0] zsum;
	logic                 z_pos;
	logic signed [SW-1:0] prod_ext, scaled, scaled_sh;
	logic signed [MW-1:0] coord, coord_lim, coord_clamped;
	logic [DEP_W-1:0]     rd_dep;
	logic [SHADE_W-1:0]   rd_shade, shade_new;
	logic [19:0]          d_times12;
	logic                 better;
	logic                 out_load;

	assign cmd_in       = cmd_t'(req.command);
	assign sel_in_range = (32'(req.cell_select) < CELLS);

	tpzr_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cord_req),
		.rsp    (cord_rsp)
	);

	tpzr_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tpzr_frame_mem #(
		.DEPTH (CELLS),
		.AW    (AW),
		.DW    (FRAME_DW)
	) u_frame_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (cell_q),
		.rdata (mem_rdata)
	);

	// Configuration registers are written whenever the channel offers data.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_q <= '0;
			spin_q <= '0;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_TILT: tilt_q <= cfg.data;
				REG_SPIN: spin_q <= cfg.data;
				default:  ;
			endcase
		end
	end

	// Shared multiplier operands: the rotation microprogram, then the two projections.
	assign d_ext = signed'(MW'(d_q));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_PX: begin
				mul_a = x3_q;
				mul_b = d_ext;
			end
			S_PY: begin
				mul_a = y3_q;
				mul_b = d_ext;
			end
			default: begin
				unique case (step_q)
					MS_SASB:    begin mul_a = sa_q; mul_b = sb_q; end
					MS_CYCA:    begin mul_a = cy_q; mul_b = ca_q; end
					MS_CBCP:    begin mul_a = cb_q; mul_b = cp_q; end
					MS_T1SP_M:  begin mul_a = t1_q; mul_b = sp_q; end
					MS_CXM_X:   begin mul_a = cx_q; mul_b = m_q;  end
					MS_T2SB_X:  begin mul_a = t2_q; mul_b = sb_q; end
					MS_SACB:    begin mul_a = sa_q; mul_b = cb_q; end
					MS_SBCP:    begin mul_a = sb_q; mul_b = cp_q; end
					MS_T1SP_MN: begin mul_a = t1_q; mul_b = sp_q; end
					MS_CXM_Y:   begin mul_a = cx_q; mul_b = m_q;  end
					MS_T2CB_Y:  begin mul_a = t2_q; mul_b = cb_q; end
					MS_CACX:    begin mul_a = ca_q; mul_b = cx_q; end
					MS_T1SP_Z:  begin mul_a = t1_q; mul_b = sp_q; end
					MS_CYSA_Z:  begin mul_a = cy_q; mul_b = sa_q; end
					default:    ;
				endcase
			end
		endcase
	end

	// Q2.14 product, rounded half up with a flooring shift.
	assign rnd_full = (prod_q + ROUND_HALF) >>> 14;
	assign rnd      = rnd_full[MW-1:0];

	// The depth divisor is z plus the five-unit push away from the viewer.
	assign zsum  = z3_q + Z_OFFSET;
	assign z_pos = !zsum[MW-1] && (zsum != '0);

	// Projection: the product x*D (or y*D) times 30 (or 15), floored by 2^30, then
	// offset to the frame center and clamped to the frame.
	always_comb begin
		prod_ext = SW'(prod_q);
		if (state_q == S_PXS) begin
			scaled    = (prod_ext <<< 5) - (prod_ext <<< 1);
			coord_lim = MW'(COLUMNS - 1);
		end else begin
			scaled    = (prod_ext <<< 4) - prod_ext;
			coord_lim = MW'(ROWS - 1);
		end
		scaled_sh = scaled >>> 30;
		if (state_q == S_PXS) begin
			coord = scaled_sh[MW-1:0] + MW'(COLUMNS / 2);
		end else begin
			coord = scaled_sh[MW-1:0] + MW'(ROWS / 2);
		end
		if (coord < 0) begin
			coord_clamped = '0;
		end else if (coord > coord_lim) begin
			coord_clamped = coord_lim;
		end else begin
			coord_clamped = coord;
		end
	end

	// Depth test against the stored cell, and the shade code of the new depth.
	always_comb begin
		rd_dep    = mem_rdata[FRAME_DW-1:SHADE_W];
		rd_shade  = mem_rdata[SHADE_W-1:0];
		better    = (d_q > rd_dep);
		d_times12 = (20'(d_q) << 3) + (20'(d_q) << 2);
		shade_new = (d_times12[19:16] > SHADE_MAX) ? SHADE_MAX : d_times12[19:16];
	end

	assign out_load = (state_q == S_RESP) && (!out_valid_q || rsp.ready);

	// Sequencer: next state and the strobes to the shared units and the frame store.
	always_comb begin
		state_d        = state_q;
		req.ready      = 1'b0;
		cord_req.start = 1'b0;
		cord_req.angle = tube_q;
		div_req.start  = 1'b0;
		div_req.num    = DIV_NUM_BASE + NUM_W'(zsum[MW-1:1]);
		div_req.den    = DEN_W'(zsum);
		mem_we         = 1'b0;
		mem_waddr      = cell_q;
		mem_wdata      = {d_q, shade_new};
		mem_re         = 1'b0;
		unique case (state_q)
			S_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = {{DEP_W{1'b0}}, SHADE_BLANK};
				if (clr_addr_q == AW'(CELLS - 1)) begin
					state_d = sweep_rsp_q ? S_RESP : S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					unique case (cmd_in)
						CMD_CLEAR: state_d = S_SWEEP;
						CMD_PLOT: begin
							cord_req.start = 1'b1;
							cord_req.angle = req.tube_angle;
							state_d        = S_CORDIC;
						end
						CMD_READ: state_d = sel_in_range ? S_ADDR : S_RESP;
						CMD_NOP:  state_d = S_RESP;
						default:  state_d = S_RESP;
					endcase
				end
			end
			S_CORDIC: begin
				if (cord_rsp.done) begin
					unique case (ang_q)
						TS_TUBE: begin
							cord_req.start = 1'b1;
							cord_req.angle = ring_q;
						end
						TS_RING: begin
							cord_req.start = 1'b1;
							cord_req.angle = tilt_q;
						end
						TS_TILT: begin
							cord_req.start = 1'b1;
							cord_req.angle = spin_q;
						end
						TS_SPIN: state_d = S_MUL;
						default: state_d = S_MUL;
					endcase
				end
			end
			S_MUL: state_d = S_ACC;
			S_ACC: state_d = (step_q == MS_CYSA_Z) ? S_ZADD : S_MUL;
			S_ZADD: begin
				div_req.start = z_pos;
				state_d       = z_pos ? S_DIV : S_PX;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					state_d = S_PX;
				end
			end
			S_PX:   state_d = S_PXS;
			S_PXS:  state_d = S_PY;
			S_PY:   state_d = S_PYS;
			S_PYS:  state_d = S_CELL;
			S_CELL: state_d = S_ADDR;
			S_ADDR: begin
				mem_re  = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				mem_we  = !is_read_q && better;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers. Reset starts the clearing walk of the frame store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			ang_q       <= TS_TUBE;
			step_q      <= MS_SASB;
			clr_addr_q  <= '0;
			sweep_rsp_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SWEEP) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (state_q == S_IDLE && req.valid) begin
				ang_q       <= TS_TUBE;
				step_q      <= MS_SASB;
				clr_addr_q  <= '0;
				sweep_rsp_q <= (cmd_in == CMD_CLEAR);
			end
			if (state_q == S_CORDIC && cord_rsp.done) begin
				ang_q <= trig_sel_t'(ang_q + 2'd1);
			end
			if (state_q == S_ACC) begin
				step_q <= mac_step_t'(step_q + 4'd1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					tube_q      <= req.tube_angle;
					ring_q      <= req.ring_angle;
					is_read_q   <= (cmd_in == CMD_READ);
					cell_q      <= AW'(req.cell_select);
					res_index_q <= (cmd_in == CMD_READ) ? req.cell_select : '0;
					res_char_q  <= ramp_char(SHADE_BLANK);
					res_upd_q   <= 1'b0;
					res_dep_q   <= '0;
				end
			end
			S_CORDIC: begin
				if (cord_rsp.done) begin
					unique case (ang_q)
						TS_TUBE: begin
							cx_q <= RING_RADIUS + MW'(cord_rsp.cos_v);
							cy_q <= MW'(cord_rsp.sin_v);
						end
						TS_RING: begin
							cp_q <= MW'(cord_rsp.cos_v);
							sp_q <= MW'(cord_rsp.sin_v);
						end
						TS_TILT: begin
							ca_q <= MW'(cord_rsp.cos_v);
							sa_q <= MW'(cord_rsp.sin_v);
						end
						TS_SPIN: begin
							cb_q <= MW'(cord_rsp.cos_v);
							sb_q <= MW'(cord_rsp.sin_v);
						end
						default: ;
					endcase
				end
			end
			S_MUL, S_PX, S_PY: prod_q <= mul_a * mul_b;
			S_ACC: begin
				unique case (step_q)
					MS_SASB:    t1_q <= rnd;
					MS_CYCA:    t2_q <= rnd;
					MS_CBCP:    m_q  <= rnd;
					MS_T1SP_M:  m_q  <= m_q + rnd;
					MS_CXM_X:   x3_q <= rnd;
					MS_T2SB_X:  x3_q <= x3_q - rnd;
					MS_SACB:    t1_q <= rnd;
					MS_SBCP:    m_q  <= rnd;
					MS_T1SP_MN: m_q  <= m_q - rnd;
					MS_CXM_Y:   y3_q <= rnd;
					MS_T2CB_Y:  y3_q <= y3_q + rnd;
					MS_CACX:    t1_q <= rnd;
					MS_T1SP_Z:  z3_q <= rnd;
					MS_CYSA_Z:  z3_q <= z3_q + rnd;
					default:    ;
				endcase
			end
			S_ZADD: begin
				if (!z_pos) begin
					d_q <= DEPTH_SAT;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					d_q <= (|div_rsp.quo[NUM_W-1:DEP_W]) ? DEPTH_SAT : div_rsp.quo[DEP_W-1:0];
				end
			end
			S_PXS: col_q <= CW'(coord_clamped);
			S_PYS: row_q <= RW'(coord_clamped);
			S_CELL: cell_q <= AW'(col_q) + AW'(COLUMNS) * AW'(row_q);
			S_CMP: begin
				res_index_q <= IDX_W'(cell_q);
				if (is_read_q) begin
					res_char_q <= ramp_char(rd_shade);
					res_upd_q  <= 1'b0;
					res_dep_q  <= rd_dep;
				end else begin
					res_char_q <= ramp_char(better ? shade_new : rd_shade);
					res_upd_q  <= better;
					res_dep_q  <= d_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_index_q <= res_index_q;
			out_char_q  <= res_char_q;
			out_upd_q   <= res_upd_q;
			out_dep_q   <= res_dep_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.cell_index  = out_index_q;
	assign rsp.cell_char   = out_char_q;
	assign rsp.updated     = out_upd_q;
	assign rsp.depth_value = out_dep_q;

	// The frame store is written only by the clearing walk or a passing depth test.
	a_mem_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SWEEP || state_q == S_CMP))
		else $error("frame store written outside the clear walk and the depth test");

	// A cell that passed the depth test holds a depth above zero.
	a_update_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.updated) |-> (rsp.depth_value != '0))
		else $error("updated result carries a zero depth");

	// The shared units finish only while the sequencer waits for them.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide step");

	a_cordic_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cord_rsp.done |-> (state_q == S_CORDIC))
		else $error("rotator finished outside the rotation step");

	// A plotted cell lies inside the frame.
	a_update_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.updated) |-> (32'(rsp.cell_index) < CELLS))
		else $error("updated cell index lies outside the frame");

endmodule

// ----- bench/torus_point_zbuffer_render_test.sv -----
// Self-checking bench for the torus point renderer: random commands, random handshake gaps,
// and a fixed-point predictor of the depth-buffered frame.
// Depends on tpzr_pkg, the three channel interfaces and torus_point_zbuffer_render.
module torus_point_zbuffer_render_test;
	import tpzr_pkg::*;

	localparam int COLS  = DEF_COLUMNS;
	localparam int ROWS_N = DEF_ROWS;
	localparam int CELLS = COLS * ROWS_N;
	localparam int LIMIT_CYCLES = 2000000;

	typedef struct {
		cmd_t        command;
		logic [15:0] tube_angle;
		logic [15:0] ring_angle;
		logic [10:0] cell_select;
	} command_t;

	typedef struct {
		logic [10:0] cell_index;
		logic [7:0]  cell_char;
		logic        updated;
		logic [15:0] depth_value;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tpzr_cfg_if cfg();
	tpzr_in_if  req();
	tpzr_out_if rsp();

	torus_point_zbuffer_render dut (.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req), .rsp(rsp));

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor copy of the frame and of the two rotation angles.
	logic [15:0] model_depth [CELLS];
	logic [3:0]  model_shade [CELLS];
	logic [15:0] tilt_q, spin_q;

	command_t      pending_cmds [$];
	pixel_result_t expected_pixels [$];
	int   mismatches = 0;
	int   cycle_count = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	bit   driving = 1'b0;
	// Set by the monitor when the command channel completed a transaction at the last edge.
	bit   in_taken = 1'b0;

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return shr_floor(a * b + 8192, 14);
	endfunction

	// 16-step rotation toward the angle, from a prescaled unit vector.
	function automatic void trig_of(logic [15:0] angle, output longint c, output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = angle;
		x = 9949;
		y = 0;
		flip = 0;
		if (z >= 16384 && z < 49152) begin
			z -= 32768;
			flip = 1;
		end else if (z >= 49152) begin
			z -= 65536;
		end
		for (int i = 0; i < 16; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(i[3:0]);
			end else begin
				x += dx; y -= dy; z += atan_step(i[3:0]);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = x;
		s = y;
	endfunction

	function automatic void clear_frame();
		for (int i = 0; i < CELLS; i++) begin
			model_depth[i] = '0;
			model_shade[i] = SHADE_BLANK;
		end
	endfunction

	function automatic pixel_result_t render_command(command_t cm);
		pixel_result_t r;
		longint ct, st, cp, sp, ca, sa, cb, sb, cx, cy, m, x3, y3, z3, d, col, row, code;
		int cell_no;
		r = '{cell_index: '0, cell_char: " ", updated: 1'b0, depth_value: '0};
		case (cm.command)
			CMD_CLEAR: clear_frame();
			CMD_PLOT: begin
				trig_of(cm.tube_angle, ct, st);
				trig_of(cm.ring_angle, cp, sp);
				trig_of(tilt_q, ca, sa);
				trig_of(spin_q, cb, sb);
				cx = 32768 + ct;
				cy = st;
				m  = qmul(cb, cp) + qmul(qmul(sa, sb), sp);
				x3 = qmul(cx, m) - qmul(qmul(cy, ca), sb);
				m  = qmul(sb, cp) - qmul(qmul(sa, cb), sp);
				y3 = qmul(cx, m) + qmul(qmul(cy, ca), cb);
				z3 = qmul(qmul(ca, cx), sp) + qmul(cy, sa) + 81920;
				if (z3 <= 0) d = 65535;
				else begin
					d = ((64'sd1 << 30) + z3 / 2) / z3;
					if (d > 65535) d = 65535;
				end
				col = COLS / 2 + shr_floor(x3 * d * 30, 30);
				row = ROWS_N / 2 + shr_floor(y3 * d * 15, 30);
				col = col < 0 ? 0 : (col > COLS - 1 ? COLS - 1 : col);
				row = row < 0 ? 0 : (row > ROWS_N - 1 ? ROWS_N - 1 : row);
				cell_no = int'(col + COLS * row);
				if (d > model_depth[cell_no]) begin
					code = (d * 12) >>> 16;
					if (code > 11) code = 11;
					model_depth[cell_no] = d[15:0];
					model_shade[cell_no] = code[3:0];
					r.updated = 1'b1;
				end
				r.cell_index  = cell_no[10:0];
				r.cell_char   = ramp_char(model_shade[cell_no]);
				r.depth_value = d[15:0];
			end
			CMD_READ: begin
				r.cell_index = cm.cell_select;
				if (cm.cell_select < CELLS) begin
					r.cell_char   = ramp_char(model_shade[cm.cell_select]);
					r.depth_value = model_depth[cm.cell_select];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	// Driver: the command channel changes only on the falling edge. A command that is
	// offered but not yet taken stays on the channel unchanged.
	always @(negedge clk) begin
		if (driving && pending_cmds.size() > 0 &&
				((req.valid && !in_taken) || $urandom_range(99) >= send_idle_pct)) begin
			req.valid       <= 1'b1;
			req.command     <= pending_cmds[0].command;
			req.tube_angle  <= pending_cmds[0].tube_angle;
			req.ring_angle  <= pending_cmds[0].ring_angle;
			req.cell_select <= pending_cmds[0].cell_select;
		end else begin
			req.valid <= 1'b0;
		end
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: predict on accepted commands, check accepted results.
	always @(posedge clk) begin
		pixel_result_t want;
		cycle_count++;
		in_taken = arst_n && req.valid && req.ready;
		if (in_taken) begin
			expected_pixels.push_back(render_command('{command: cmd_t'(req.command),
				tube_angle: req.tube_angle, ring_angle: req.ring_angle,
				cell_select: req.cell_select}));
			void'(pending_cmds.pop_front());
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected result, cell", rsp.cell_index, -1);
			end else begin
				want = expected_pixels.pop_front();
				if (rsp.cell_index !== want.cell_index)
					report_mismatch("cell_index", rsp.cell_index, want.cell_index);
				if (rsp.cell_char !== want.cell_char)
					report_mismatch("cell_char", rsp.cell_char, want.cell_char);
				if (rsp.updated !== want.updated)
					report_mismatch("updated", rsp.updated, want.updated);
				if (rsp.depth_value !== want.depth_value)
					report_mismatch("depth_value", rsp.depth_value, want.depth_value);
			end
		end
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("torus_point_zbuffer_render test failed");
			$finish;
		end
	end

	// Register writes go out only when nothing is in flight.
	task automatic write_angle(reg_idx_t idx, logic [15:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_TILT) tilt_q = value;
		else spin_q = value;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic push_cmd(cmd_t c, logic [15:0] t, logic [15:0] r, logic [10:0] s);
		pending_cmds.push_back('{command: c, tube_angle: t, ring_angle: r, cell_select: s});
	endtask

	// Let the queued commands drain and the block settle before the next phase.
	task automatic drain();
		driving = 1'b1;
		wait (pending_cmds.size() == 0 && !req.valid);
		wait (expected_pixels.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		req.valid = 1'b0;
		req.command = CMD_NOP;
		req.tube_angle = '0;
		req.ring_angle = '0;
		req.cell_select = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_TILT;
		cfg.data = '0;
		tilt_q = '0;
		spin_q = '0;
		clear_frame();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: angle extremes, every command, out-of-range reads, a depth-test loss.
		write_angle(REG_TILT, 16'h0000);
		write_angle(REG_SPIN, 16'hFFFF);
		push_cmd(CMD_READ, 16'h0, 16'h0, 11'd0);
		push_cmd(CMD_PLOT, 16'h0000, 16'h0000, 11'h7FF);
		push_cmd(CMD_PLOT, 16'h0000, 16'h0000, 11'd0);
		push_cmd(CMD_PLOT, 16'hFFFF, 16'hFFFF, 11'd0);
		push_cmd(CMD_PLOT, 16'h4000, 16'hC000, 11'd0);
		push_cmd(CMD_PLOT, 16'h8000, 16'h8000, 11'd0);
		push_cmd(CMD_READ, 16'hFFFF, 16'hFFFF, 11'd1919);
		push_cmd(CMD_READ, 16'h0, 16'h0, 11'd1920);
		push_cmd(CMD_READ, 16'h0, 16'h0, 11'h7FF);
		push_cmd(CMD_NOP, 16'hFFFF, 16'hFFFF, 11'h7FF);
		push_cmd(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 11'h7FF);
		push_cmd(CMD_PLOT, 16'h2000, 16'h6000, 11'd0);
		push_cmd(CMD_READ, 16'h0, 16'h0, 11'd40 + 11'd80 * 11'd12);
		drain();

		// Random phases over several angle settings and idling mixes.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
				3: begin send_idle_pct = 33; recv_stall_pct = 33; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			write_angle(REG_TILT, ph == 4 ? 16'hFFFF : 16'($urandom));
			write_angle(REG_SPIN, ph == 4 ? 16'h0000 : 16'($urandom));
			for (int n = 0; n < 100; n++) begin
				int pick;
				pick = $urandom_range(99);
				if (pick < 70)
					push_cmd(CMD_PLOT, 16'($urandom), 16'($urandom), 11'($urandom));
				else if (pick < 90)
					push_cmd(CMD_READ, 16'($urandom), 16'($urandom),
						$urandom_range(9) == 0 ? 11'($urandom) : 11'($urandom_range(CELLS - 1)));
				else if (pick < 95)
					push_cmd(CMD_NOP, 16'($urandom), 16'($urandom), 11'($urandom));
				else
					push_cmd(CMD_CLEAR, 16'($urandom), 16'($urandom), 11'($urandom));
			end
			drain();
		end

		if (mismatches == 0)
			$display("torus_point_zbuffer_render test passed");
		else
			$display("torus_point_zbuffer_render test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/tpzr_pkg.sv
hdl/tpzr_cfg_if.sv
hdl/tpzr_in_if.sv
hdl/tpzr_out_if.sv
hdl/tpzr_cordic.sv
hdl/tpzr_divider.sv
hdl/tpzr_frame_mem.sv
hdl/torus_point_zbuffer_render.sv
bench/torus_point_zbuffer_render_test.sv
